@@ rtl/abl_pkg.sv @@
// Shared types and constants for the accelerometer bias lock block.
// No dependencies; imported by every module under rtl/.
package abl_pkg;

  // Default widths for the top-level parameters
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int COUNT_WIDTH_DEF  = 32;

  // Fixed field widths
  localparam int NUM_AXES     = 3;
  localparam int SUM_W        = 48;
  localparam int CFG_W        = 16;
  localparam int CFG_ADDR_W   = 3;
  localparam int LOCK_COUNT_W = 16;
  localparam int THR_W        = 15;

  // Register reset values
  localparam logic [LOCK_COUNT_W-1:0] LOCK_COUNT_RST = 16'd100;
  localparam logic [THR_W-1:0]        THR_RST        = 15'd819;  // 0.2 in Q3.12

  // Deviation is scaled down by this divisor
  localparam int DEV_DIVISOR = 3;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_LOCK_COUNT = 3'd0,
    CFG_RELOCK_THR = 3'd1,
    CFG_PREV_X     = 3'd2,
    CFG_PREV_Y     = 3'd3,
    CFG_PREV_Z     = 3'd4,
    CFG_TEMP_OFS   = 3'd5
  } cfg_reg_e;

  // Output phase codes
  typedef enum logic [1:0] {
    PH_PASS   = 2'd0,
    PH_LOCK   = 2'd1,
    PH_LOCKED = 2'd2
  } phase_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_ROUTE,
    ST_MEAN,
    ST_DEV,
    ST_DEVW,
    ST_FINISH
  } ctrl_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;     // latch request, update count and sums
    logic eval;       // latch phase
    logic div_start;  // start the mean divider lanes
    logic mean_load;  // capture mean quotient
    logic dev_step;   // capture deviation magnitude and sign
    logic dev_load;   // capture deviation over three
    logic out_load;   // write result register and state
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    phase_e phase;
    logic   div_busy;
    logic   out_free;
  } dp_status_t;

endpackage

@@ rtl/abl_div.sv @@
// Serial restoring divider lane: signed dividend by unsigned divisor, truncating.
// One quotient bit per cycle. Depends on abl_pkg.
module abl_div
  import abl_pkg::*;
#(
  parameter int DVD_W = SUM_W,
  parameter int DVS_W = COUNT_WIDTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [DVD_W-1:0] dividend_i,
  input  logic        [DVS_W-1:0] divisor_i,
  output logic                    busy_o,
  output logic signed [DVD_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] acc_q, acc_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic             neg_q, neg_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;

  logic [DVD_W-1:0] mag;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   trial_sub;
  logic             ge;

  // magnitude of the dividend; the most negative value maps to its unsigned pattern
  assign mag       = dividend_i[DVD_W-1] ? (~dividend_i + DVD_W'(1)) : dividend_i;
  assign trial     = {rem_q, acc_q[DVD_W-1]};
  assign trial_sub = trial - {1'b0, dvs_q};
  assign ge        = (trial >= {1'b0, dvs_q});

  // next-state: load on start, one shift-subtract step per cycle while busy
  always_comb begin
    acc_d  = acc_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      acc_d  = mag;
      rem_d  = '0;
      dvs_d  = divisor_i;
      neg_d  = dividend_i[DVD_W-1];
      cnt_d  = CNT_W'(DVD_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
      acc_d = {acc_q[DVD_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // operand and quotient registers
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = neg_q ? -$signed(acc_q) : $signed(acc_q);

  // a started division is in progress on the next cycle
  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_o)
    else $error("divider not busy after start");

endmodule

@@ rtl/abl_dp.sv @@
// Datapath: config registers, count and sums, three mean divider lanes, result register.
// Depends on abl_pkg and abl_div.
module abl_dp
  import abl_pkg::*;
#(
  parameter int SW = SAMPLE_WIDTH_DEF,
  parameter int CW = COUNT_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ctrl_cmd_t              cmd_i,
  output dp_status_t             sts_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  input  logic signed [SW-1:0]   smp_i [NUM_AXES],
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [SW-1:0]   res_o [NUM_AXES],
  output logic [1:0]             phase_o
);

  localparam int LW      = (SW > CFG_W) ? SW : CFG_W;
  localparam int CMPW    = (CW > LOCK_COUNT_W) ? CW : LOCK_COUNT_W;
  localparam int DVD_W   = SUM_W;

  localparam logic signed [LW+1:0] RES_MAX = {{(LW + 3 - SW){1'b0}}, {(SW - 1){1'b1}}};
  localparam logic signed [LW+1:0] RES_MIN = ~RES_MAX;
  localparam logic [SUM_W:0] SUM_POS = {2'b00, {(SUM_W - 1){1'b1}}};
  localparam logic [SUM_W:0] SUM_NEG = {2'b11, {(SUM_W - 1){1'b0}}};

  // ceil(2^(SW+2) / 3): exact floor(n / 3) for every n below 2^SW
  localparam logic [SW:0] DIV3_RECIP =
    (SW + 1)'(((64'd1 << (SW + 2)) + 64'(DEV_DIVISOR - 1)) / 64'(DEV_DIVISOR));

  // configuration registers
  logic [LOCK_COUNT_W-1:0] lock_cnt_q;
  logic [THR_W-1:0]        thr_q;
  logic signed [CFG_W-1:0] prev_q [NUM_AXES];
  logic signed [CFG_W-1:0] temp_q;

  // state
  logic [CW-1:0]              count_q;
  logic signed [SUM_W-1:0]    sum_q   [NUM_AXES];
  logic signed [SUM_W-1:0]    sum_d   [NUM_AXES];
  logic signed [SW-1:0]       smp_q   [NUM_AXES];
  logic signed [SW-1:0]       mean_q  [NUM_AXES];
  logic signed [SW:0]         dev3_q  [NUM_AXES];
  logic signed [LW-1:0]       lock_q  [NUM_AXES];
  logic signed [SW-1:0]       last_q  [NUM_AXES];
  logic signed [SW-1:0]       out_q   [NUM_AXES];
  logic signed [SW-1:0]       res     [NUM_AXES];
  logic signed [LW-1:0]       lock_d  [NUM_AXES];
  logic [NUM_AXES-1:0]        in_tol;
  logic [NUM_AXES-1:0]        busy;
  phase_e                     phase_q, phase_now, out_phase_q;
  logic                       out_valid_q;
  logic                       at_max;
  logic                       keep;

  // config write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_cnt_q <= LOCK_COUNT_RST;
      thr_q      <= THR_RST;
      temp_q     <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        prev_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CFG_LOCK_COUNT: lock_cnt_q <= cfg_wdata_i[LOCK_COUNT_W-1:0];
        CFG_RELOCK_THR: thr_q      <= cfg_wdata_i[THR_W-1:0];
        CFG_PREV_X:     prev_q[0]  <= cfg_wdata_i;
        CFG_PREV_Y:     prev_q[1]  <= cfg_wdata_i;
        CFG_PREV_Z:     prev_q[2]  <= cfg_wdata_i;
        CFG_TEMP_OFS:   temp_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // count and sums freeze once the count is all ones
  assign at_max = &count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        sum_q[i] <= '0;
      end
    end else if (cmd_i.accept && !at_max) begin
      count_q <= count_q + CW'(1);
      for (int i = 0; i < NUM_AXES; i++) begin
        sum_q[i] <= sum_d[i];
      end
    end
  end

  // request sample capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        smp_q[i] <= smp_i[i];
      end
    end
  end

  // phase from the updated count
  always_comb begin
    if (CMPW'(count_q) < CMPW'(lock_cnt_q)) begin
      phase_now = PH_PASS;
    end else if (CMPW'(count_q) == CMPW'(lock_cnt_q)) begin
      phase_now = PH_LOCK;
    end else begin
      phase_now = PH_LOCKED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PASS;
    end else if (cmd_i.eval) begin
      phase_q <= phase_now;
    end
  end

  // per-axis lanes
  for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
    logic signed [SUM_W:0]    sum_ext;
    logic signed [SW:0]       dev;
    logic        [SW:0]       dev_abs;
    logic        [SW-1:0]     dev_mag_q;
    logic                     dev_neg_q;
    logic        [2*SW:0]     prod;
    logic        [SW-2:0]     quo3;
    logic        [SW:0]       quo3_ext;
    logic signed [SW:0]       dev3;
    logic signed [DVD_W-1:0]  quo;
    logic signed [LW+1:0]     diff;
    logic signed [LW+1:0]     absd;
    logic signed [LW+1:0]     base;
    logic signed [LW+1:0]     val;
    logic signed [SW-1:0]     sat;

    // saturating accumulate
    assign sum_ext  = (SUM_W + 1)'(sum_q[g]) + (SUM_W + 1)'(smp_i[g]);
    assign sum_d[g] = (sum_ext[SUM_W] != sum_ext[SUM_W-1])
                    ? (sum_ext[SUM_W] ? SUM_NEG[SUM_W-1:0] : SUM_POS[SUM_W-1:0])
                    : sum_ext[SUM_W-1:0];

    // |mean| never exceeds the sample range, so SW bits hold it
    assign dev     = (SW + 1)'(smp_q[g]) - (SW + 1)'(mean_q[g]);
    assign dev_abs = dev[SW] ? -dev : dev;

    abl_div #(
      .DVD_W (DVD_W),
      .DVS_W (CW)
    ) u_div (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (cmd_i.div_start),
      .dividend_i (sum_q[g]),
      .divisor_i  (count_q),
      .busy_o     (busy[g]),
      .quo_o      (quo)
    );

    // deviation over three: magnitude times reciprocal, sign put back, truncates
    assign prod     = (2 * SW + 1)'(dev_mag_q) * (2 * SW + 1)'(DIV3_RECIP);
    assign quo3     = prod[2*SW:SW+2];
    assign quo3_ext = {2'b00, quo3};
    assign dev3     = dev_neg_q ? $signed(-quo3_ext) : $signed(quo3_ext);

    always_ff @(posedge clk_i) begin
      if (cmd_i.mean_load) begin
        mean_q[g] <= quo[SW-1:0];
      end
      if (cmd_i.dev_step) begin
        dev_mag_q <= dev_abs[SW-1:0];
        dev_neg_q <= dev[SW];
      end
      if (cmd_i.dev_load) begin
        dev3_q[g] <= dev3;
      end
    end

    // relock tolerance check
    assign diff      = (LW + 2)'(prev_q[g]) - (LW + 2)'(mean_q[g]);
    assign absd      = diff[LW+1] ? -diff : diff;
    assign in_tol[g] = (absd <= $signed({{(LW + 2 - THR_W){1'b0}}, thr_q}));
    assign lock_d[g] = keep ? (LW)'(prev_q[g]) : (LW)'(mean_q[g]);

    // locked output: x takes the offset away, y and z add it
    if (g == 0) begin : g_sub
      assign base = (LW + 2)'(lock_q[g]) - (LW + 2)'(temp_q);
    end else begin : g_add
      assign base = (LW + 2)'(lock_q[g]) + (LW + 2)'(temp_q);
    end
    assign val = base + (LW + 2)'(dev3_q[g]);
    assign sat = (val > RES_MAX) ? RES_MAX[SW-1:0]
               : (val < RES_MIN) ? RES_MIN[SW-1:0] : val[SW-1:0];

    always_comb begin
      unique case (phase_q)
        PH_PASS:   res[g] = smp_q[g];
        PH_LOCK:   res[g] = last_q[g];
        PH_LOCKED: res[g] = sat;
        default:   res[g] = sat;
      endcase
    end
  end

  assign keep = &in_tol;

  // result state: last outputs and lock values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        last_q[i] <= '0;
        lock_q[i] <= '0;
      end
    end else if (cmd_i.out_load) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        last_q[i] <= res[i];
        if (phase_q == PH_LOCK) begin
          lock_q[i] <= lock_d[i];
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_phase_q <= phase_q;
      for (int i = 0; i < NUM_AXES; i++) begin
        out_q[i] <= res[i];
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign res_o          = out_q;
  assign phase_o        = out_phase_q;
  assign sts_o.phase    = phase_q;
  assign sts_o.div_busy = |busy;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // a pending result is never overwritten
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> sts_o.out_free)
    else $error("result register overwritten");

  // count steps by one on each request until it saturates
  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept && !at_max) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("sample count did not advance");

endmodule

@@ rtl/abl_ctrl.sv @@
// Controller FSM: sequences accept, mean division, deviation scaling, result write.
// Depends on abl_pkg.
module abl_ctrl
  import abl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t sts_i,
  output ctrl_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_EVAL;
      ST_EVAL:   state_d = ST_ROUTE;
      ST_ROUTE:  state_d = (sts_i.phase == PH_PASS) ? ST_FINISH : ST_MEAN;
      ST_MEAN: begin
        if (!sts_i.div_busy) begin
          state_d = (sts_i.phase == PH_LOCK) ? ST_FINISH : ST_DEV;
        end
      end
      ST_DEV:    state_d = ST_DEVW;
      ST_DEVW:   state_d = ST_FINISH;
      ST_FINISH: if (sts_i.out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_EVAL:   cmd_o.eval = 1'b1;
      ST_ROUTE:  cmd_o.div_start = (sts_i.phase != PH_PASS);
      ST_MEAN:   cmd_o.mean_load = !sts_i.div_busy;
      ST_DEV:    cmd_o.dev_step = 1'b1;
      ST_DEVW:   cmd_o.dev_load = 1'b1;
      ST_FINISH: cmd_o.out_load = sts_i.out_free;
      default: ;
    endcase
  end

  // divider is never restarted mid-run
  a_start_idle_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !sts_i.div_busy)
    else $error("divider restarted while busy");

  // no new request while a division is running
  a_ready_idle_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !sts_i.div_busy)
    else $error("request taken during division");

endmodule

@@ rtl/accel_bias_lock.sv @@
// Accelerometer bias lock, top level; uses abl_pkg, abl_ctrl, abl_dp (abl_div).
// After eval and route a request goes to the result write before the lock count, through
// the mean division at the lock sample, and through it and the divide by three after it.
// The mean divider is 48-step serial per axis; the divide by three is a reciprocal step in
// DEV and DEVW. A request is taken while a finished result waits.
// Async active-low reset: count, sums, lock values, last outputs zero; config to defaults.
module accel_bias_lock
  import abl_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]         cfg_addr_i,
  input  logic [CFG_W-1:0]              cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_x_i,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_y_i,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] out_x_o,
  output logic signed [SAMPLE_WIDTH-1:0] out_y_o,
  output logic signed [SAMPLE_WIDTH-1:0] out_z_o,
  output logic [1:0]                    phase_o
);

  ctrl_cmd_t                    cmd;
  dp_status_t                   sts;
  logic signed [SAMPLE_WIDTH-1:0] smp [NUM_AXES];
  logic signed [SAMPLE_WIDTH-1:0] res [NUM_AXES];

  assign smp[0] = accel_x_i;
  assign smp[1] = accel_y_i;
  assign smp[2] = accel_z_i;

  abl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  abl_dp #(
    .SW (SAMPLE_WIDTH),
    .CW (COUNT_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .smp_i       (smp),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res),
    .phase_o     (phase_o)
  );

  assign out_x_o = res[0];
  assign out_y_o = res[1];
  assign out_z_o = res[2];

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for accel_bias_lock: running-mean bias lock on 3-axis samples.
// Depends on rtl/abl_pkg.sv and rtl/accel_bias_lock.sv; holds its own bit-exact predictor.
`timescale 1ns / 100ps

import abl_pkg::*;

// Tracks block state, predicts each output and checks it against what arrives
class bias_lock_tracker;
  typedef struct {
    logic signed [SAMPLE_WIDTH_DEF-1:0] val [3];
    phase_e                             phase;
  } axis_result_t;

  // register copies
  longint lock_count;
  longint relock_thr;
  longint prev_lock [3];
  longint temp_ofs;

  // block state
  longint sample_cnt;
  longint axis_sum  [3];
  longint lock_val  [3];
  longint last_out  [3];

  axis_result_t owed_outputs [$];
  int           errors;

  function new();
    lock_count = LOCK_COUNT_RST;
    relock_thr = THR_RST;
    temp_ofs   = 0;
    sample_cnt = 0;
    errors     = 0;
    for (int a = 0; a < NUM_AXES; a++) begin
      prev_lock[a] = 0;
      axis_sum[a]  = 0;
      lock_val[a]  = 0;
      last_out[a]  = 0;
    end
  endfunction

  function longint sat_sample(longint v);
    longint hi;
    hi = (longint'(1) <<< (SAMPLE_WIDTH_DEF - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function longint sat_sum(longint v);
    longint hi;
    hi = (longint'(1) <<< (SUM_W - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // Running mean, truncated toward zero
  function longint mean_of(int a);
    if (sample_cnt == 0) return 0;
    return axis_sum[a] / sample_cnt;
  endfunction

  function void write_reg(cfg_reg_e idx, logic [CFG_W-1:0] val);
    logic signed [CFG_W-1:0] sval;
    sval = val;
    case (idx)
      CFG_LOCK_COUNT: lock_count = val;
      CFG_RELOCK_THR: relock_thr = val[THR_W-1:0];
      CFG_PREV_X:     prev_lock[0] = sval;
      CFG_PREV_Y:     prev_lock[1] = sval;
      CFG_PREV_Z:     prev_lock[2] = sval;
      CFG_TEMP_OFS:   temp_ofs = sval;
      default: ;
    endcase
  endfunction

  // Accepted request: advance state and queue the output it causes
  function void note_sample(logic signed [SAMPLE_WIDTH_DEF-1:0] x,
                            logic signed [SAMPLE_WIDTH_DEF-1:0] y,
                            logic signed [SAMPLE_WIDTH_DEF-1:0] z);
    longint       smp  [3];
    longint       mean [3];
    longint       res  [3];
    longint       cnt_max;
    longint       base;
    bit           keep;
    axis_result_t r;
    smp[0]  = x;
    smp[1]  = y;
    smp[2]  = z;
    cnt_max = (longint'(1) <<< COUNT_WIDTH_DEF) - 1;

    // count and sums freeze at the count maximum
    if (sample_cnt < cnt_max) begin
      sample_cnt++;
      for (int a = 0; a < NUM_AXES; a++) axis_sum[a] = sat_sum(axis_sum[a] + smp[a]);
    end
    for (int a = 0; a < NUM_AXES; a++) mean[a] = mean_of(a);

    if (sample_cnt < lock_count) begin
      r.phase = PH_PASS;
      for (int a = 0; a < NUM_AXES; a++) res[a] = smp[a];
    end else if (sample_cnt == lock_count) begin
      // lock sample: keep old lock only if every axis is within tolerance
      r.phase = PH_LOCK;
      keep    = 1'b1;
      for (int a = 0; a < NUM_AXES; a++) begin
        base = prev_lock[a] - sat_sample(mean[a]);
        if ((base < 0 ? -base : base) > relock_thr) keep = 1'b0;
      end
      for (int a = 0; a < NUM_AXES; a++) begin
        lock_val[a] = keep ? prev_lock[a] : sat_sample(mean[a]);
        res[a]      = last_out[a];
      end
    end else begin
      r.phase = PH_LOCKED;
      for (int a = 0; a < NUM_AXES; a++) begin
        base   = (a == 0) ? lock_val[a] - temp_ofs : lock_val[a] + temp_ofs;
        res[a] = sat_sample(base + (smp[a] - mean[a]) / DEV_DIVISOR);
      end
    end

    for (int a = 0; a < NUM_AXES; a++) begin
      last_out[a] = res[a];
      r.val[a]    = res[a][SAMPLE_WIDTH_DEF-1:0];
    end
    owed_outputs.push_back(r);
  endfunction

  function void check_output(logic signed [SAMPLE_WIDTH_DEF-1:0] x,
                             logic signed [SAMPLE_WIDTH_DEF-1:0] y,
                             logic signed [SAMPLE_WIDTH_DEF-1:0] z,
                             logic [1:0] ph);
    axis_result_t                       e;
    logic signed [SAMPLE_WIDTH_DEF-1:0] got [3];
    got[0] = x;
    got[1] = y;
    got[2] = z;
    if (owed_outputs.size() == 0) begin
      $display("%0t: output with no request pending: %0d %0d %0d phase %0d",
               $time, x, y, z, ph);
      errors++;
      return;
    end
    e = owed_outputs.pop_front();
    for (int a = 0; a < NUM_AXES; a++) begin
      if (got[a] !== e.val[a]) begin
        $display("%0t: axis %0d expected %0d actual %0d", $time, a, e.val[a], got[a]);
        errors++;
      end
    end
    if (ph !== e.phase) begin
      $display("%0t: phase expected %0d actual %0d", $time, e.phase, ph);
      errors++;
    end
  endfunction
endclass

module tb;
  import abl_pkg::*;

  localparam int SW           = SAMPLE_WIDTH_DEF;
  localparam int NUM_ITEMS    = 1100;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 80;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_ADDR_W-1:0]  cfg_addr_i;
  logic [CFG_W-1:0]       cfg_wdata_i;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic signed [SW-1:0]   accel_x_i;
  logic signed [SW-1:0]   accel_y_i;
  logic signed [SW-1:0]   accel_z_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic signed [SW-1:0]   out_x_o;
  logic signed [SW-1:0]   out_y_o;
  logic signed [SW-1:0]   out_z_o;
  logic [1:0]             phase_o;

  bias_lock_tracker tracker;
  int               gap_pct;
  int               stall_pct;
  int               quiet_cycles;

  accel_bias_lock u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .accel_x_i   (accel_x_i),
    .accel_y_i   (accel_y_i),
    .accel_z_i   (accel_z_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_z_o     (out_z_o),
    .phase_o     (phase_o)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // output side: random backpressure, check each accepted output
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) tracker.check_output(out_x_o, out_y_o, out_z_o, phase_o);
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog: too long without any handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // one register write, block idle
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    tracker.write_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // one request; valid stays high afterwards unless the next call idles
  task automatic send_sample(input logic signed [SW-1:0] x, input logic signed [SW-1:0] y,
                             input logic signed [SW-1:0] z);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    accel_x_i  <= x;
    accel_y_i  <= y;
    accel_z_i  <= z;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.note_sample(x, y, z);
  endtask

  function automatic logic signed [SW-1:0] near_value(input longint center, input int amp);
    return SW'(tracker.sat_sample(center + int'($urandom_range(2 * amp)) - amp));
  endfunction

  // request spread around the current running mean
  task automatic send_near(input int amp);
    send_sample(near_value(tracker.mean_of(0), amp), near_value(tracker.mean_of(1), amp),
                near_value(tracker.mean_of(2), amp));
  endtask

  task automatic send_random();
    send_sample(SW'($urandom), SW'($urandom), SW'($urandom));
  endtask

  // stop requests, let all outputs drain, then settle
  task automatic wait_drained(input int settle);
    in_valid_i <= 1'b0;
    while (tracker.owed_outputs.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // place the lock n_pre samples ahead; previous lock near the mean or anywhere
  task automatic arm_lock(input int n_pre, input int thr, input bit near_mean);
    longint v;
    write_reg(CFG_LOCK_COUNT, CFG_W'(tracker.sample_cnt + n_pre));
    write_reg(CFG_RELOCK_THR, CFG_W'(thr));
    for (int a = 0; a < NUM_AXES; a++) begin
      if (near_mean) begin
        v = tracker.sat_sample(tracker.mean_of(a) + int'($urandom_range(16)) - 8);
      end else begin
        v = longint'($urandom);
      end
      write_reg(cfg_reg_e'(int'(CFG_PREV_X) + a), CFG_W'(v));
    end
  endtask

  initial begin
    int n_sent;
    int n_pre;
    int n_post;
    int amp;
    int thr;
    int roll;

    tracker      = new();
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_addr_i   = '0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    accel_x_i    = '0;
    accel_y_i    = '0;
    accel_z_i    = '0;
    out_ready_i  = 1'b0;
    gap_pct      = 0;
    stall_pct    = 0;
    quiet_cycles = 0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // lock on the very first sample: outputs repeat the zero reset value
    write_reg(CFG_LOCK_COUNT, 16'd1);
    send_sample(16'sh7fff, -16'sh8000, 16'sd1);
    // locked outputs with field extremes and alternating bits
    send_sample(-16'sh8000, 16'sh7fff, 16'sd0);
    send_sample(16'sh5555, 16'shaaaa, 16'shffff);
    send_sample(16'shaaaa, 16'sh5555, 16'sh7fff);
    send_sample(16'sd0, 16'sd0, -16'sh8000);
    send_sample(-16'sd1, 16'sd1, 16'sh7fff);

    // temperature offset extremes drive saturation both ways
    wait_drained(4);
    write_reg(CFG_TEMP_OFS, 16'h8000);
    send_sample(16'sh7fff, -16'sh8000, -16'sh8000);
    send_sample(-16'sh8000, 16'sh7fff, 16'sh7fff);
    wait_drained(4);
    write_reg(CFG_TEMP_OFS, 16'h7fff);
    send_sample(16'sh7fff, -16'sh8000, 16'sh7fff);
    send_sample(-16'sh8000, 16'sh7fff, -16'sh8000);

    // lock count zero: every sample is a locked output
    wait_drained(4);
    write_reg(CFG_TEMP_OFS, 16'h0000);
    write_reg(CFG_LOCK_COUNT, 16'd0);
    send_sample(16'sd100, -16'sd100, 16'sd4096);
    send_sample(16'sd3, -16'sd3, 16'sd2);

    // relock within widest tolerance keeps the previous values
    wait_drained(4);
    arm_lock(3, 32767, 1'b1);
    repeat (3) send_near(0);
    send_near(0);
    // zero tolerance against far values takes the new mean
    wait_drained(4);
    arm_lock(2, 0, 1'b0);
    send_sample(16'sh7fff, 16'sh7fff, -16'sh8000);
    send_sample(-16'sh8000, -16'sh8000, 16'sh7fff);
    send_random();
    // lock far beyond the run: pure passthrough
    wait_drained(4);
    write_reg(CFG_LOCK_COUNT, 16'hffff);
    send_sample(-16'sh8000, -16'sh8000, -16'sh8000);
    send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);

    // random lock episodes
    n_sent = 0;
    while (n_sent < NUM_ITEMS) begin
      wait_drained(4);
      if (n_sent < NUM_ITEMS / 3) begin
        gap_pct   = 13;
        stall_pct = 87;
      end else if (n_sent < 2 * NUM_ITEMS / 3) begin
        gap_pct   = 87;
        stall_pct = 13;
      end else begin
        gap_pct   = 0;
        stall_pct = 0;
      end

      case ($urandom_range(5))
        0:       write_reg(CFG_TEMP_OFS, 16'h8000);
        1:       write_reg(CFG_TEMP_OFS, 16'h7fff);
        default: write_reg(CFG_TEMP_OFS, CFG_W'(int'($urandom_range(600)) - 300));
      endcase

      roll   = $urandom_range(7);
      n_post = $urandom_range(4, 30);
      if (roll == 0) begin
        // always locked
        write_reg(CFG_LOCK_COUNT, 16'd0);
        for (int i = 0; i < n_post; i++) begin
          if ($urandom_range(1)) send_random();
          else send_near($urandom_range(3000));
        end
        n_sent += n_post;
      end else if (roll == 1) begin
        // never reaches the lock
        write_reg(CFG_LOCK_COUNT, 16'hffff);
        for (int i = 0; i < n_post; i++) send_random();
        n_sent += n_post;
      end else begin
        case ($urandom_range(3))
          0:       thr = 0;
          1:       thr = 32767;
          2:       thr = THR_RST;
          default: thr = $urandom_range(1, 2000);
        endcase
        n_pre = $urandom_range(1, 12);
        arm_lock(n_pre, thr, $urandom_range(3) != 0);
        amp = $urandom_range(64);
        for (int i = 0; i < n_pre; i++) send_near(amp);
        for (int i = 0; i < n_post; i++) begin
          if ($urandom_range(3) == 0) send_random();
          else send_near($urandom_range(3000));
        end
        n_sent += n_pre + n_post;
      end
    end

    wait_drained(DRAIN_CYCLES);
    if (tracker.owed_outputs.size() != 0) begin
      $display("%0t: %0d outputs never arrived", $time, tracker.owed_outputs.size());
    end
    if (tracker.errors == 0 && tracker.owed_outputs.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ accel_bias_lock.f @@
rtl/abl_pkg.sv
rtl/abl_div.sv
rtl/abl_dp.sv
rtl/abl_ctrl.sv
rtl/accel_bias_lock.sv
tb/tb.sv
